// ----- hdl/tbsd_pkg.sv -----
// Package for the three-bus swing drift block: shared constants, codes and types.
// Used by tbsd_sincos, tbsd_network and the top level; depends on nothing.
package tbsd_pkg;

    localparam int DEF_FRAC_BITS     = 24;
    localparam int DEF_CORDIC_STAGES = 24;
    localparam int NUM_REGS          = 7;
    localparam int ATAN_ENTRIES      = 30;

    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_GAIN    = 64'd652032874;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [3:0] IDX_Y_LAST = 4'd8;
    localparam logic [3:0] IDX_E1     = 4'd9;
    localparam logic [3:0] IDX_E2     = 4'd10;
    localparam logic [3:0] IDX_EREF   = 4'd11;

    localparam logic [2:0] REG_OMEGA  = 3'd0;
    localparam logic [2:0] REG_GAMMA  = 3'd1;
    localparam logic [2:0] REG_INV1   = 3'd2;
    localparam logic [2:0] REG_INV2   = 3'd3;
    localparam logic [2:0] REG_INVREF = 3'd4;
    localparam logic [2:0] REG_DRIVE1 = 3'd5;
    localparam logic [2:0] REG_DRIVE2 = 3'd6;

    typedef struct packed {
        logic               act;
        logic [3:0]         idx;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] om1;
        logic signed [31:0] om2;
    } item_t;

    typedef struct packed {
        logic signed [31:0] omega_base;
        logic signed [31:0] damping_gamma;
        logic signed [31:0] inv_2h1;
        logic signed [31:0] inv_2h2;
        logic signed [31:0] inv_2href;
        logic signed [31:0] drive_1;
        logic signed [31:0] drive_2;
    } cfg_t;

endpackage

// ----- hdl/tbsd_delay.sv -----
// Delay line that carries an item's side fields and its valid bit.
// Depends on nothing; sized by parameters from the top level.
module tbsd_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic         vld_reg  [0:DEPTH-1];
    logic [W-1:0] data_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ----- hdl/tbsd_sincos.sv -----
// Pipelined phase reduction and CORDIC cosine and sine for one phase.
// Depends on tbsd_pkg for the Q30 constants and the arctangent table.
module tbsd_sincos #(
    parameter int FRAC_BITS     = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic               clk,
    input  logic signed [31:0] phase,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);
    import tbsd_pkg::*;

    localparam int SH    = 30 - FRAC_BITS;
    localparam int QBITS = 29 - FRAC_BITS;
    localparam int RW    = 62 - FRAC_BITS;
    localparam int AW    = 35;
    localparam int XW    = 34;

    localparam logic signed [AW-1:0] PI_S      = AW'(Q30_PI);
    localparam logic signed [AW-1:0] TWO_PI_S  = AW'(Q30_TWO_PI);
    localparam logic signed [AW-1:0] HALF_PI_S = AW'(Q30_HALF_PI);
    localparam logic signed [XW-1:0] GAIN_S    = XW'(Q30_GAIN);
    localparam logic signed [XW-1:0] HALF_LSB  = XW'(1) <<< (SH - 1);

    logic signed [RW:0]   r_wide;
    logic [RW-1:0]        mag_reg  [0:QBITS];
    logic                 neg_reg  [0:QBITS];
    logic signed [AW-1:0] mpos;
    logic signed [AW-1:0] rem;
    logic signed [AW-1:0] r1;
    logic signed [AW-1:0] r2_next;
    logic                 flip_next;
    logic signed [XW-1:0] x_reg    [0:CORDIC_STAGES];
    logic signed [XW-1:0] y_reg    [0:CORDIC_STAGES];
    logic signed [AW-1:0] z_reg    [0:CORDIC_STAGES];
    logic                 flip_reg [0:CORDIC_STAGES];
    logic signed [XW-1:0] xf;

    assign r_wide = {{(RW - 31){phase[31]}}, phase} <<< SH;

    always_ff @(posedge clk)
    begin
        mag_reg[0] <= r_wide[RW] ? RW'(-r_wide) : RW'(r_wide);
        neg_reg[0] <= r_wide[RW];
    end

    for (genvar d = 0; d < QBITS; d++)
    begin : g_div
        localparam logic [RW-1:0] DIV = RW'(Q30_TWO_PI) << (QBITS - 1 - d);
        always_ff @(posedge clk)
        begin
            mag_reg[d+1] <= (mag_reg[d] >= DIV) ? mag_reg[d] - DIV : mag_reg[d];
            neg_reg[d+1] <= neg_reg[d];
        end
    end

    always_comb
    begin
        mpos = AW'(mag_reg[QBITS][32:0]);
        rem  = neg_reg[QBITS] ? -mpos : mpos;
        r1   = rem;
        if (rem > PI_S)
        begin
            r1 = rem - TWO_PI_S;
        end
        else if (rem < -PI_S)
        begin
            r1 = rem + TWO_PI_S;
        end
        r2_next   = r1;
        flip_next = 1'b0;
        if (r1 > HALF_PI_S)
        begin
            r2_next   = PI_S - r1;
            flip_next = 1'b1;
        end
        else if (r1 < -HALF_PI_S)
        begin
            r2_next   = -PI_S - r1;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= GAIN_S;
        y_reg[0]    <= '0;
        z_reg[0]    <= r2_next;
        flip_reg[0] <= flip_next;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        localparam logic signed [AW-1:0] AT = AW'(ATAN_Q30[i]);
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][AW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - AT;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + AT;
            end
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    assign xf = flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        cos_q <= 32'((xf + HALF_LSB) >>> SH);
        sin_q <= 32'((y_reg[CORDIC_STAGES] + HALF_LSB) >>> SH);
    end

endmodule

// ----- hdl/tbsd_network.sv -----
// Network pipeline: phasors, bus currents, electrical powers and drift rates.
// Depends on tbsd_pkg; holds the magnitude and admittance stores.
module tbsd_network #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tbsd_pkg::item_t    in_item,
    input  tbsd_pkg::cfg_t     cfg,
    input  logic signed [31:0] cos1,
    input  logic signed [31:0] sin1,
    input  logic signed [31:0] cos2,
    input  logic signed [31:0] sin2,
    output logic               done,
    output logic signed [31:0] rate_phase_1,
    output logic signed [31:0] rate_phase_2,
    output logic signed [31:0] rate_speed_1,
    output logic signed [31:0] rate_speed_2,
    output logic               saturated
);
    import tbsd_pkg::*;

    localparam int QW = 64 - FRAC_BITS;
    localparam int SW = QW + 4;

    function automatic logic signed [QW-1:0] qrnd(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (FRAC_BITS - 1));
        return QW'(t >>> FRAC_BITS);
    endfunction

    function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
        logic [32:0] r;
        if (v > SW'(64'sh7FFFFFFF))
        begin
            r = {1'b1, 32'h7FFFFFFF};
        end
        else if (v < -SW'(64'sh80000000))
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic signed [31:0] e_mem_reg [0:2];
    logic signed [31:0] g_mem_reg [0:8];
    logic signed [31:0] b_mem_reg [0:8];

    logic               v1_reg;
    logic               v2_reg;
    item_t              it1_reg;
    item_t              it2_reg;
    logic               ev_reg   [3:10];
    logic               flag_reg [2:10];

    logic signed [63:0] p_er_reg [0:1];
    logic signed [63:0] p_ei_reg [0:1];
    logic signed [63:0] p_om_reg [0:1];
    logic signed [63:0] p_gm_reg [0:1];
    logic signed [31:0] eref_reg;

    logic signed [31:0] er_reg [2:5][0:2];
    logic signed [31:0] ei_reg [2:5][0:2];
    logic signed [31:0] rp_reg [2:10][0:1];
    logic signed [QW-1:0] qg_reg [2:9][0:1];

    logic signed [63:0] pgr_reg [0:2][0:2];
    logic signed [63:0] pbi_reg [0:2][0:2];
    logic signed [63:0] pgi_reg [0:2][0:2];
    logic signed [63:0] pbr_reg [0:2][0:2];
    logic signed [QW:0] tr_reg  [0:2][0:2];
    logic signed [QW:0] ti_reg  [0:2][0:2];
    logic signed [31:0] ir_reg  [0:2];
    logic signed [31:0] ii_reg  [0:2];
    logic signed [63:0] ppr_reg [0:2];
    logic signed [63:0] ppi_reg [0:2];
    logic signed [31:0] pe_reg  [0:2];
    logic signed [63:0] ps1_reg;
    logic signed [63:0] ps2_reg;
    logic signed [63:0] psr_reg;
    logic signed [31:0] s_reg   [0:1];
    logic signed [31:0] rs_reg  [0:1];

    logic signed [31:0] er_next [0:2];
    logic signed [31:0] ei_next [0:2];
    logic signed [31:0] rp_next [0:1];
    logic               flag2_next;
    logic signed [31:0] ir_next [0:2];
    logic signed [31:0] ii_next [0:2];
    logic               flag5_next;
    logic signed [31:0] pe_next [0:2];
    logic               flag7_next;
    logic signed [31:0] s_next  [0:1];
    logic               flag9_next;
    logic signed [31:0] rs_next [0:1];
    logic               flag10_next;

    // Control: valid bits and the evaluate marks that run down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int s = 3; s <= 10; s++)
            begin
                ev_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            ev_reg[3] <= v2_reg && (it2_reg.act == ACT_EVAL);
            for (int s = 4; s <= 10; s++)
            begin
                ev_reg[s] <= ev_reg[s-1];
            end
        end
    end

    // Magnitudes are written where they are read, at the pipeline entry.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_item.act == ACT_LOAD)
        begin
            case (in_item.idx)
                IDX_E1:   e_mem_reg[0] <= in_item.a;
                IDX_E2:   e_mem_reg[1] <= in_item.a;
                IDX_EREF: e_mem_reg[2] <= in_item.a;
                default:  ;
            endcase
        end
    end

    // Admittances are written where they are read, two stages later.
    always_ff @(posedge clk)
    begin
        if (v2_reg && it2_reg.act == ACT_LOAD && it2_reg.idx <= IDX_Y_LAST)
        begin
            g_mem_reg[it2_reg.idx] <= it2_reg.a;
            b_mem_reg[it2_reg.idx] <= it2_reg.b;
        end
    end

    always_comb
    begin : s2_comb
        logic [32:0] t;
        flag2_next = 1'b0;
        for (int j = 0; j < 2; j++)
        begin
            t = sat32(SW'(qrnd(p_er_reg[j])));
            er_next[j] = t[31:0];
            flag2_next = flag2_next | t[32];
            t = sat32(SW'(qrnd(p_ei_reg[j])));
            ei_next[j] = t[31:0];
            flag2_next = flag2_next | t[32];
            t = sat32(SW'(qrnd(p_om_reg[j])));
            rp_next[j] = t[31:0];
            flag2_next = flag2_next | t[32];
        end
        er_next[2] = eref_reg;
        ei_next[2] = '0;
    end

    always_comb
    begin : s5_comb
        logic [32:0] t;
        flag5_next = flag_reg[4];
        for (int k = 0; k < 3; k++)
        begin
            t = sat32(SW'(tr_reg[k][0]) + SW'(tr_reg[k][1]) + SW'(tr_reg[k][2]));
            ir_next[k] = t[31:0];
            flag5_next = flag5_next | t[32];
            t = sat32(SW'(ti_reg[k][0]) + SW'(ti_reg[k][1]) + SW'(ti_reg[k][2]));
            ii_next[k] = t[31:0];
            flag5_next = flag5_next | t[32];
        end
    end

    always_comb
    begin : s7_comb
        logic [32:0] t;
        flag7_next = flag_reg[6];
        for (int k = 0; k < 3; k++)
        begin
            t = sat32(SW'(qrnd(ppr_reg[k])) + SW'(qrnd(ppi_reg[k])));
            pe_next[k] = t[31:0];
            flag7_next = flag7_next | t[32];
        end
    end

    always_comb
    begin : s9_comb
        logic [32:0] t;
        flag9_next = flag_reg[8];
        t = sat32(SW'(qrnd(ps1_reg)) - SW'(qrnd(psr_reg)));
        s_next[0] = t[31:0];
        flag9_next = flag9_next | t[32];
        t = sat32(SW'(qrnd(ps2_reg)) - SW'(qrnd(psr_reg)));
        s_next[1] = t[31:0];
        flag9_next = flag9_next | t[32];
    end

    always_comb
    begin : s10_comb
        logic [32:0] t;
        flag10_next = flag_reg[9];
        t = sat32(SW'(cfg.drive_1) - SW'(qg_reg[9][0]) - SW'(s_reg[0]));
        rs_next[0] = t[31:0];
        flag10_next = flag10_next | t[32];
        t = sat32(SW'(cfg.drive_2) - SW'(qg_reg[9][1]) - SW'(s_reg[1]));
        rs_next[1] = t[31:0];
        flag10_next = flag10_next | t[32];
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: phasor and speed products.
        it1_reg     <= in_item;
        p_er_reg[0] <= e_mem_reg[0] * cos1;
        p_ei_reg[0] <= e_mem_reg[0] * sin1;
        p_er_reg[1] <= e_mem_reg[1] * cos2;
        p_ei_reg[1] <= e_mem_reg[1] * sin2;
        p_om_reg[0] <= cfg.omega_base * in_item.om1;
        p_om_reg[1] <= cfg.omega_base * in_item.om2;
        p_gm_reg[0] <= cfg.damping_gamma * in_item.om1;
        p_gm_reg[1] <= cfg.damping_gamma * in_item.om2;
        eref_reg    <= e_mem_reg[2];

        // Stage 2: rounded and clipped phasors.
        it2_reg     <= it1_reg;
        flag_reg[2] <= flag2_next;
        for (int j = 0; j < 3; j++)
        begin
            er_reg[2][j] <= er_next[j];
            ei_reg[2][j] <= ei_next[j];
        end
        for (int j = 0; j < 2; j++)
        begin
            rp_reg[2][j] <= rp_next[j];
            qg_reg[2][j] <= qrnd(p_gm_reg[j]);
        end

        // Stage 3: admittance products.
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pgr_reg[k][j] <= g_mem_reg[k*3+j] * er_reg[2][j];
                pbi_reg[k][j] <= b_mem_reg[k*3+j] * ei_reg[2][j];
                pgi_reg[k][j] <= g_mem_reg[k*3+j] * ei_reg[2][j];
                pbr_reg[k][j] <= b_mem_reg[k*3+j] * er_reg[2][j];
            end
        end

        // Stage 4: rounded current terms.
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                tr_reg[k][j] <= (QW+1)'(qrnd(pgr_reg[k][j])) - (QW+1)'(qrnd(pbi_reg[k][j]));
                ti_reg[k][j] <= (QW+1)'(qrnd(pgi_reg[k][j])) + (QW+1)'(qrnd(pbr_reg[k][j]));
            end
        end

        // Stage 5: bus currents.
        for (int k = 0; k < 3; k++)
        begin
            ir_reg[k] <= ir_next[k];
            ii_reg[k] <= ii_next[k];
        end

        // Stage 6: power products.
        for (int k = 0; k < 3; k++)
        begin
            ppr_reg[k] <= er_reg[5][k] * ir_reg[k];
            ppi_reg[k] <= ei_reg[5][k] * ii_reg[k];
        end

        // Stage 7: electrical powers.
        for (int k = 0; k < 3; k++)
        begin
            pe_reg[k] <= pe_next[k];
        end

        // Stage 8: inertia scaling.
        ps1_reg <= pe_reg[0] * cfg.inv_2h1;
        ps2_reg <= pe_reg[1] * cfg.inv_2h2;
        psr_reg <= pe_reg[2] * cfg.inv_2href;

        // Stage 9 and 10: differences and final drift.
        s_reg[0]     <= s_next[0];
        s_reg[1]     <= s_next[1];
        rs_reg[0]    <= rs_next[0];
        rs_reg[1]    <= rs_next[1];
        flag_reg[5]  <= flag5_next;
        flag_reg[7]  <= flag7_next;
        flag_reg[9]  <= flag9_next;
        flag_reg[10] <= flag10_next;
        flag_reg[3]  <= flag_reg[2];
        flag_reg[4]  <= flag_reg[3];
        flag_reg[6]  <= flag_reg[5];
        flag_reg[8]  <= flag_reg[7];

        for (int s = 3; s <= 5; s++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                er_reg[s][j] <= er_reg[s-1][j];
                ei_reg[s][j] <= ei_reg[s-1][j];
            end
        end
        for (int j = 0; j < 2; j++)
        begin
            for (int s = 3; s <= 10; s++)
            begin
                rp_reg[s][j] <= rp_reg[s-1][j];
            end
            for (int s = 3; s <= 9; s++)
            begin
                qg_reg[s][j] <= qg_reg[s-1][j];
            end
        end
    end

    assign done         = ev_reg[10];
    assign rate_phase_1 = rp_reg[10][0];
    assign rate_phase_2 = rp_reg[10][1];
    assign rate_speed_1 = rs_reg[0];
    assign rate_speed_2 = rs_reg[1];
    assign saturated    = flag_reg[10];

`ifndef ASSERT_OFF
    a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && it1_reg.act == ACT_EVAL) |-> ##9 done)
        else $error("An evaluate item did not produce a result.");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && it1_reg.act == ACT_LOAD) |-> ##9 !done)
        else $error("A load item produced a result.");

    a_zero_omega: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_item.act == ACT_EVAL && cfg.omega_base == 32'sd0)
        |-> ##10 (done && rate_phase_1 == 32'sd0 && rate_phase_2 == 32'sd0))
        else $error("Phase drift is not zero with a zero base frequency.");
`endif

endmodule

// ----- hdl/three_bus_swing_drift.sv -----
// Top level of the three-bus swing drift block: configuration registers and pipeline.
// Depends on tbsd_pkg, tbsd_delay, tbsd_sincos and tbsd_network.
//
// Usage: an item is accepted at each rising edge with start high; busy is
// always low, so one item may enter in every cycle. A load item (action 0)
// writes one coefficient entry and returns nothing. An evaluate item
// (action 1) returns one result: done is high for exactly one cycle with the
// four drift rates and the saturated flag on the result ports.
// The latency of an evaluate item is set by the restoring phase reduction,
// one CORDIC stage per iteration and ten network stages. Throughput is one
// item per cycle. Results leave in item order. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no item is in flight, which the block does not enforce. Index 7
// is ignored. Reset clears the configuration registers and all valid bits;
// coefficient entries hold nothing until loaded. The receiver cannot stall
// the block.
module three_bus_swing_drift
    import tbsd_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [3:0]         coeff_index,
    input  logic signed [31:0] coeff_a,
    input  logic signed [31:0] coeff_b,
    input  logic signed [31:0] phase_1,
    input  logic signed [31:0] phase_2,
    input  logic signed [31:0] speed_dev_1,
    input  logic signed [31:0] speed_dev_2,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic signed [31:0] cfg_data,
    output logic               done,
    output logic signed [31:0] rate_phase_1,
    output logic signed [31:0] rate_phase_2,
    output logic signed [31:0] rate_speed_1,
    output logic signed [31:0] rate_speed_2,
    output logic               saturated
);

    localparam int LAT_SC = (29 - FRAC_BITS) + CORDIC_STAGES + 3;

    cfg_t               cfg_reg;
    item_t              in_item;
    item_t              dl_item;
    logic               dl_valid;
    logic signed [31:0] cos1;
    logic signed [31:0] sin1;
    logic signed [31:0] cos2;
    logic signed [31:0] sin2;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OMEGA:  cfg_reg.omega_base    <= cfg_data;
                REG_GAMMA:  cfg_reg.damping_gamma <= cfg_data;
                REG_INV1:   cfg_reg.inv_2h1       <= cfg_data;
                REG_INV2:   cfg_reg.inv_2h2       <= cfg_data;
                REG_INVREF: cfg_reg.inv_2href     <= cfg_data;
                REG_DRIVE1: cfg_reg.drive_1       <= cfg_data;
                REG_DRIVE2: cfg_reg.drive_2       <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign in_item.act = action;
    assign in_item.idx = coeff_index;
    assign in_item.a   = coeff_a;
    assign in_item.b   = coeff_b;
    assign in_item.om1 = speed_dev_1;
    assign in_item.om2 = speed_dev_2;

    tbsd_delay #(
        .W     ($bits(item_t)),
        .DEPTH (LAT_SC)
    ) u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_data   (in_item),
        .out_valid (dl_valid),
        .out_data  (dl_item)
    );

    tbsd_sincos #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sincos_1 (
        .clk   (clk),
        .phase (phase_1),
        .cos_q (cos1),
        .sin_q (sin1)
    );

    tbsd_sincos #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sincos_2 (
        .clk   (clk),
        .phase (phase_2),
        .cos_q (cos2),
        .sin_q (sin2)
    );

    tbsd_network #(
        .FRAC_BITS (FRAC_BITS)
    ) u_network (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dl_valid),
        .in_item      (dl_item),
        .cfg          (cfg_reg),
        .cos1         (cos1),
        .sin1         (sin1),
        .cos2         (cos2),
        .sin2         (sin2),
        .done         (done),
        .rate_phase_1 (rate_phase_1),
        .rate_phase_2 (rate_phase_2),
        .rate_speed_1 (rate_speed_1),
        .rate_speed_2 (rate_speed_2),
        .saturated    (saturated)
    );

endmodule
